// File: rtl/tcw_pkg.sv
// tcw_pkg: shared constants, codes, types and control/status structs
// for the text console writer; no dependencies
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 11;
    localparam int OFFSET_W   = 11;
    localparam int ATTR_W     = 8;
    localparam int WORD_W     = ATTR_W + CHAR_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
    localparam logic [WORD_W-1:0] BLANK_RESET = 16'h0720;

    localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_DRAIN
    } tcw_state_t;

    typedef enum logic [1:0] {
        SWEEP_INIT,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } sweep_kind_t;

    typedef struct packed {
        logic        accept;
        logic        execute;
        logic        sweep_start;
        sweep_kind_t sweep_kind;
        logic        sweep_step;
        logic        load_out;
    } dp_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             scroll_needed;
        logic             sweep_last;
        logic             sweep_init;
        logic             out_free;
    } dp_stat_t;

endpackage

// File: rtl/tcw_if.sv
// tcw_if: valid/ready channel interfaces for commands and responses
// depends on tcw_pkg
interface tcw_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CMD_W-1:0]     command;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::CELL_W-1:0]    cell_index;

    modport source (output valid, output command, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input command, input char_code, input cell_index,
                    output ready);
endinterface

interface tcw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::OFFSET_W-1:0]  cursor_offset;
    logic [tcw_pkg::WORD_W-1:0]    read_data;

    modport source (output valid, output cursor_offset, output read_data, input ready);
    modport sink   (input valid, input cursor_offset, input read_data, output ready);
endinterface

// File: rtl/tcw_ram.sv
// tcw_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tcw_controller.sv
// tcw_controller: sequencing state machine for execute, sweep and result handoff
// depends on tcw_pkg
module tcw_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcw_pkg::dp_stat_t stat,
    output tcw_pkg::dp_ctrl_t ctrl
);
    import tcw_pkg::*;

    tcw_state_t state_reg, state_next;
    logic       result_pend_reg, result_pend_next;
    logic       ready_int;
    logic       out_take;

    assign ready_int = (state_reg == ST_IDLE) && (!result_pend_reg || stat.out_free);
    assign out_take  = (state_reg == ST_IDLE) && result_pend_reg && stat.out_free;

    always_comb
    begin
        state_next       = state_reg;
        result_pend_next = result_pend_reg;
        if (out_take)
        begin
            result_pend_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_int)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((stat.command == CMD_CLEAR) ||
                    ((stat.command == CMD_PUT) && stat.scroll_needed))
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next       = ST_IDLE;
                    result_pend_next = 1'b1;
                end
            end
            ST_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
                if (!stat.sweep_init)
                begin
                    result_pend_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = ready_int;
        ctrl.accept      = in_valid && ready_int;
        ctrl.execute     = (state_reg == ST_EXEC);
        ctrl.sweep_start = (state_reg == ST_EXEC) &&
                           ((stat.command == CMD_CLEAR) ||
                            ((stat.command == CMD_PUT) && stat.scroll_needed));
        ctrl.sweep_kind  = (stat.command == CMD_CLEAR) ? SWEEP_CLEAR : SWEEP_SCROLL;
        ctrl.sweep_step  = (state_reg == ST_SWEEP);
        ctrl.load_out    = out_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            result_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            result_pend_reg <= result_pend_next;
        end
    end

endmodule

// File: rtl/tcw_datapath.sv
// tcw_datapath: cursor logic, cell store, sweep address engine, result register
// and attribute register; depends on tcw_pkg and tcw_ram
module tcw_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcw_pkg::dp_ctrl_t              ctrl,
    output tcw_pkg::dp_stat_t              stat,
    input  logic [tcw_pkg::CMD_W-1:0]      command,
    input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
    input  logic [tcw_pkg::CELL_W-1:0]     cell_index,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [tcw_pkg::OFFSET_W-1:0]   cursor_offset,
    output logic [tcw_pkg::WORD_W-1:0]     read_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0] prdata
);
    import tcw_pkg::*;

    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [CHAR_W-1:0]   code_reg, code_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ATTR_W-1:0]   attr_reg, attr_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    sweep_kind_t         kind_reg, kind_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                pend_copy_reg, pend_copy_next;
    logic                out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [WORD_W-1:0]   out_data_reg, out_data_next;

    logic [ADDR_W-1:0]   cur_idx;
    logic                printable;
    logic [COL_W-1:0]    col_put, col_wrap;
    logic [ROW_W-1:0]    row_put, row_wrap, row_fin;
    logic                put_write;
    logic                scroll;
    logic                copy_now;
    logic                read_ok;
    logic                reg_hit;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [WORD_W-1:0]   mem_wdata, mem_rdata, sweep_word;

    assign cur_idx   = ADDR_W'(row_reg * COLUMNS) + ADDR_W'(col_reg);
    assign printable = (code_reg >= CHAR_SPACE) && !code_reg[CHAR_W-1];
    assign read_ok   = 32'(cell_reg) < CELL_COUNT;
    assign copy_now  = (kind_reg == SWEEP_SCROLL) && (32'(cnt_reg) < COPY_CELLS);
    assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_TEXT_ATTRIBUTE);

    // cursor update for a put, then wrap and scroll check
    always_comb
    begin
        col_put   = col_reg;
        row_put   = row_reg;
        put_write = 1'b0;
        if (code_reg == CHAR_BS)
        begin
            if (col_reg != '0)
            begin
                col_put = col_reg - 1'b1;
            end
        end
        else if (code_reg == CHAR_TAB)
        begin
            col_put = (col_reg + COL_W'(TAB_STOP)) & ~COL_W'(TAB_STOP - 1);
        end
        else if (code_reg == CHAR_CR)
        begin
            col_put = '0;
        end
        else if (code_reg == CHAR_LF)
        begin
            col_put = '0;
            row_put = row_reg + 1'b1;
        end
        else if (printable)
        begin
            put_write = 1'b1;
            col_put   = col_reg + 1'b1;
        end
        col_wrap = col_put;
        row_wrap = row_put;
        if (32'(col_put) >= COLUMNS)
        begin
            col_wrap = '0;
            row_wrap = row_put + 1'b1;
        end
        scroll  = 32'(row_wrap) >= ROWS;
        row_fin = scroll ? ROW_W'(ROWS - 1) : row_wrap;
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        code_next       = code_reg;
        cell_next       = cell_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        attr_next       = attr_reg;
        cnt_next        = cnt_reg;
        kind_next       = kind_reg;
        pend_valid_next = ctrl.sweep_step;
        pend_addr_next  = cnt_reg;
        pend_copy_next  = copy_now;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_offset_next = out_offset_reg;
        out_data_next   = out_data_reg;

        if (ctrl.accept)
        begin
            cmd_next  = command;
            code_next = char_code;
            cell_next = cell_index;
        end
        if (ctrl.execute && (cmd_reg == CMD_PUT))
        begin
            col_next = col_wrap;
            row_next = row_fin;
        end
        else if (ctrl.execute && (cmd_reg == CMD_CLEAR))
        begin
            col_next = '0;
            row_next = '0;
        end
        if (ctrl.sweep_start)
        begin
            cnt_next  = '0;
            kind_next = ctrl.sweep_kind;
        end
        else if (ctrl.sweep_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (ctrl.load_out)
        begin
            out_valid_next  = 1'b1;
            out_offset_next = OFFSET_W'(cur_idx);
            out_data_next   = ((cmd_reg == CMD_READ) && read_ok) ? mem_rdata : '0;
        end
        if (psel && penable && pwrite && reg_hit)
        begin
            attr_next = pwdata[ATTR_W-1:0];
        end
    end

    // pending write stage of the sweep wins the write port
    always_comb
    begin
        sweep_word = pend_copy_reg ? mem_rdata :
                     ((kind_reg == SWEEP_INIT) ? BLANK_RESET : {attr_reg, CHAR_SPACE});
        mem_we     = pend_valid_reg ||
                     (ctrl.execute && (cmd_reg == CMD_PUT) && put_write);
        mem_waddr  = pend_valid_reg ? pend_addr_reg : cur_idx;
        mem_wdata  = pend_valid_reg ? sweep_word : {attr_reg, code_reg};
        if (ctrl.sweep_step)
        begin
            mem_raddr = copy_now ? (cnt_reg + ADDR_W'(COLUMNS)) : cnt_reg;
        end
        else
        begin
            mem_raddr = read_ok ? ADDR_W'(cell_reg) : '0;
        end
    end

    tcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            attr_reg       <= ATTR_RESET;
            cnt_reg        <= '0;
            kind_reg       <= SWEEP_INIT;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            attr_reg       <= attr_next;
            cnt_reg        <= cnt_next;
            kind_reg       <= kind_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        code_reg       <= code_next;
        cell_reg       <= cell_next;
        pend_addr_reg  <= pend_addr_next;
        pend_copy_reg  <= pend_copy_next;
        out_offset_reg <= out_offset_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        stat.command       = cmd_reg;
        stat.scroll_needed = scroll;
        stat.sweep_last    = (cnt_reg == ADDR_W'(CELL_COUNT - 1));
        stat.sweep_init    = (kind_reg == SWEEP_INIT);
        stat.out_free      = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid     = out_valid_reg;
    assign cursor_offset = out_offset_reg;
    assign read_data     = out_data_reg;
    assign prdata        = reg_hit ? APB_DATA_W'(attr_reg) : '0;

endmodule

// File: rtl/text_console_writer_top.sv
// text_console_writer_top: 80x25 text console, controller plus datapath
// result path: input registers, execute step, then the result register once the output slot is free,
// for put, read and ignored bytes; clear and scrolling puts add one pass over all 2000 cells
// input: a new item is taken only in idle, after the execute step and any sweep of the last one
// reset: the store is swept to 0x0720 before the first input transfer;
// the attribute register is writable during that pass
module text_console_writer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    tcw_cmd_if.sink                        cmd,
    tcw_rsp_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tcw_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    assign pready = 1'b1;

    tcw_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tcw_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (cmd.command),
        .char_code     (cmd.char_code),
        .cell_index    (cmd.cell_index),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .cursor_offset (rsp.cursor_offset),
        .read_data     (rsp.read_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata)
    );

    a_exec_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> ctrl.execute)
        else $error("execute step missing after input transfer");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> stat.out_free)
        else $error("result loaded over an untaken result");

    a_no_input_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.sweep_step |-> !cmd.ready)
        else $error("input ready during cell sweep");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> rsp.valid)
        else $error("loaded result not presented");

endmodule

// File: tb/text_console_writer_top_test.sv
// text_console_writer_top_test: self-checking testbench for the text console writer
// drives commands and attribute writes, predicts every result, compares each transfer
// depends on tcw_pkg, tcw_if and text_console_writer_top
`timescale 1ns / 100ps

module text_console_writer_top_test;
    import tcw_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED      = 2'd3;
    localparam logic [CHAR_W-1:0] CHAR_LAST_PRINT = 8'h7F;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [OFFSET_W-1:0] cursor_offset;
        logic [WORD_W-1:0]   read_data;
    } console_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tcw_cmd_if cmd_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // console model state
    logic [WORD_W-1:0] screen_model [CELL_COUNT];
    logic [ATTR_W-1:0] attr_model;
    int                cur_col;
    int                cur_row;

    console_result_t expected_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int idle_cycles;
    int mismatches;
    int items_sent;
    int results_checked;
    int scroll_count;
    int clear_count;
    int attr_writes;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic console_result_t predict_item(input logic [CMD_W-1:0] c,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input logic [CELL_W-1:0] idx);
        console_result_t r;
        r.read_data = '0;
        case (c)
            CMD_PUT:
            begin
                if (ch == CHAR_BS)
                begin
                    if (cur_col != 0)
                        cur_col--;
                end
                else if (ch == CHAR_TAB)
                    cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
                else if (ch == CHAR_CR)
                    cur_col = 0;
                else if (ch == CHAR_LF)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (ch >= CHAR_SPACE && ch <= CHAR_LAST_PRINT)
                begin
                    screen_model[cur_row * COLUMNS + cur_col] = {attr_model, ch};
                    cur_col++;
                end
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS)
                begin
                    for (int i = 0; i < COPY_CELLS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (int i = COPY_CELLS; i < CELL_COUNT; i++)
                        screen_model[i] = {attr_model, CHAR_SPACE};
                    cur_row = ROWS - 1;
                    scroll_count++;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_model[i] = {attr_model, CHAR_SPACE};
                cur_col = 0;
                cur_row = 0;
                clear_count++;
            end
            CMD_READ:
            begin
                if (idx < CELL_COUNT)
                    r.read_data = screen_model[idx];
            end
            default:
            begin
            end
        endcase
        r.cursor_offset = OFFSET_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned expv,
                                 input int unsigned actv);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch in %s at %0t: expected %h, actual %h", what, $time, expv, actv);
    endtask

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch,
                             input logic [CELL_W-1:0] idx);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      = 1'b1;
        cmd_ch.command    = c;
        cmd_ch.char_code  = ch;
        cmd_ch.cell_index = idx;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_item(c, ch, idx));
        items_sent++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(CMD_PUT, ch, CELL_W'($urandom_range(2047)));
    endtask

    task automatic read_cell(input logic [CELL_W-1:0] idx);
        send_item(CMD_READ, CHAR_W'($urandom_range(255)), idx);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup and access phase for the write, then one for the read-back
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_TEXT_ATTRIBUTE, 2'b00};
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        attr_model = value;
        attr_writes++;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[ATTR_W-1:0] !== value)
            note_mismatch("attribute read-back", value, prdata[ATTR_W-1:0]);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_directed_cases();
        read_cell(11'd0);
        read_cell(11'd1999);
        read_cell(11'd2000);
        read_cell(11'h7FF);
        put_char(CHAR_BS);
        put_char(CHAR_SPACE);
        put_char(CHAR_LAST_PRINT);
        put_char(8'h41);
        put_char(8'h1F);
        put_char(8'h00);
        put_char(8'h80);
        put_char(8'hFF);
        put_char(CHAR_BS);
        read_cell(11'd2);
        put_char(CHAR_TAB);
        put_char(CHAR_CR);
        put_char(CHAR_LF);
        send_item(CMD_UNUSED, 8'hFF, 11'h7FF);
        read_cell(11'd1);
        send_item(CMD_CLEAR, 8'h00, 11'd0);
        read_cell(11'd0);
        put_char(CHAR_LAST_PRINT);
        read_cell(11'd0);
        wait_drained();
    endtask

    // mostly short lines of text ending in a line feed, with reads, controls and noise
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [ATTR_W-1:0] attr, input int count);
        int target;
        int pick;
        int len;
        int off;
        target = items_sent + count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_attribute(attr);
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(100) : $urandom_range(16);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(11) == 0)
                        put_char(CHAR_TAB);
                    else
                        put_char(CHAR_W'($urandom_range(CHAR_LAST_PRINT, CHAR_SPACE)));
                end
                pick = $urandom_range(99);
                if (pick < 15)
                    put_char(CHAR_CR);
                if (pick < 85)
                    put_char(CHAR_LF);
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    pick = $urandom_range(99);
                    off  = cur_row * COLUMNS + cur_col - $urandom_range(8);
                    if (pick < 50)
                        read_cell(CELL_W'((off < 0) ? 0 : off));
                    else if (pick < 85)
                        read_cell(CELL_W'($urandom_range(CELL_COUNT - 1)));
                    else
                        read_cell(CELL_W'($urandom_range(2047)));
                end
            end
            else if (pick < 87)
            begin
                pick = $urandom_range(2);
                if (pick == 0)
                    repeat ($urandom_range(3, 1)) put_char(CHAR_BS);
                else if (pick == 1)
                    put_char(CHAR_TAB);
                else
                    put_char(CHAR_CR);
            end
            else if (pick < 98)
            begin
                if ($urandom_range(3) == 0)
                    send_item(CMD_UNUSED, CHAR_W'($urandom_range(255)),
                              CELL_W'($urandom_range(2047)));
                else
                    put_char(CHAR_W'($urandom_range(255)));
            end
            else
                send_item(CMD_CLEAR, CHAR_W'($urandom_range(255)),
                          CELL_W'($urandom_range(2047)));
        end
        wait_drained();
    endtask

    // receiver holds off while commands keep coming, so the input backs up
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 400;
        for (int k = 0; k < 30; k++)
        begin
            if (k % 4 == 3)
                read_cell(CELL_W'(cur_row * COLUMNS));
            else if (k % 10 == 9)
                put_char(CHAR_LF);
            else
                put_char(CHAR_W'($urandom_range(CHAR_LAST_PRINT, CHAR_SPACE)));
        end
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        console_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
                note_mismatch("unexpected result", 0,
                              {rsp_ch.cursor_offset, rsp_ch.read_data});
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (rsp_ch.cursor_offset !== want.cursor_offset)
                    note_mismatch("cursor_offset", want.cursor_offset, rsp_ch.cursor_offset);
                if (rsp_ch.read_data !== want.read_data)
                    note_mismatch("read_data", want.read_data, rsp_ch.read_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_PUT;
        cmd_ch.char_code  = '0;
        cmd_ch.cell_index = '0;
        rsp_ch.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        hold_cycles       = 0;
        idle_cycles       = 0;
        mismatches        = 0;
        items_sent        = 0;
        results_checked   = 0;
        scroll_count      = 0;
        clear_count       = 0;
        attr_writes       = 0;
        attr_model        = ATTR_RESET;
        cur_col           = 0;
        cur_row           = 0;
        for (int i = 0; i < CELL_COUNT; i++)
            screen_model[i] = BLANK_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_attribute(8'hFF);
        test_directed_cases();
        test_random_traffic(38, 76, 8'h00, 190);
        test_random_traffic(76, 38, ATTR_W'($urandom_range(255)), 190);
        test_random_traffic(0, 0, ATTR_RESET, 190);
        write_attribute(ATTR_W'($urandom_range(255)));
        test_output_stall();
        repeat (16) @(posedge clk);

        $display("covered %0d commands and %0d checked results, %0d scrolls, %0d clears",
                 items_sent, results_checked, scroll_count, clear_count);
        $display("with %0d attribute writes over three idling modes and one long output stall",
                 attr_writes);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_ram.sv
rtl/tcw_controller.sv
rtl/tcw_datapath.sv
rtl/text_console_writer_top.sv
tb/text_console_writer_top_test.sv
